// ===== rtl/core/point_to_polyline_distance_assert.svh =====
// ----------------------------------------------------------------------------
// Point-to-polyline distance assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_POLYLINE_DISTANCE_ASSERT_SVH
`define POINT_TO_POLYLINE_DISTANCE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define PTPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that implies a consequence in the next cycle.
`define PTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ptpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-to-polyline distance package
// Shared constants, control types and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptpd_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_WIDTH_DEF  = 24;

	localparam int DIST_W = 24;               // result width, Q16.8
	localparam int QW     = 49;               // squared distance, capped at 2^48
	localparam int STEP_W = 6;                // step counter for wide mul and divide
	localparam logic [QW-1:0] CAP = QW'(1) << (QW - 1);
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic is_query;
		logic wr_en;     // load lands inside the store
		logic last;      // load sets the vertex count
	} item_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_LAT,
		ST_MUL,
		ST_DEC,
		ST_WIDE,
		ST_DINIT,
		ST_DIV,
		ST_NEXT,
		ST_SQRT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptpd_front.sv =====
// ----------------------------------------------------------------------------
// Point-to-polyline distance front end
// Accepts items, classifies loads and queries, and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ptpd_front #(
	parameter int MAX_VERTICES = ptpd_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = ptpd_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              req_type,
	input  logic [5:0]                        vertex_index,
	input  logic                              final_vertex,
	input  logic signed [COORD_WIDTH-1:0]     coord_x,
	input  logic signed [COORD_WIDTH-1:0]     coord_y,
	input  logic signed [COORD_WIDTH-1:0]     coord_z,
	output logic                              q_valid,
	input  logic                              q_pop,
	output ptpd_pkg::item_ctl_t               q_ctl,
	output logic [$clog2(MAX_VERTICES)-1:0]   q_widx,
	output logic [$clog2(MAX_VERTICES+1)-1:0] q_cnt,
	output logic [3*COORD_WIDTH-1:0]          q_coord
);
	import ptpd_pkg::*;

	localparam int IW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);

	item_ctl_t            ctl_d;
	item_ctl_t            ctl_q   [2];
	logic [IW-1:0]        widx_q  [2];
	logic [CNTW-1:0]      cnt_q   [2];
	logic [3*COORD_WIDTH-1:0] coord_q [2];
	logic                 wr_ptr_q, rd_ptr_q;
	logic [1:0]           fill_q;
	logic                 take;

	assign full    = (fill_q == 2'd2);
	assign q_valid = (fill_q != 2'd0);
	assign take    = push && !full;

	// classify: out-of-range loads become no-ops
	always_comb begin
		ctl_d.is_query = (req_type == REQ_QUERY);
		ctl_d.wr_en    = (req_type == REQ_LOAD) && (int'(vertex_index) < MAX_VERTICES);
		ctl_d.last     = final_vertex;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (take)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, take} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_q[wr_ptr_q]   <= ctl_d;
			widx_q[wr_ptr_q]  <= IW'(vertex_index);
			cnt_q[wr_ptr_q]   <= CNTW'(vertex_index) + CNTW'(1);
			coord_q[wr_ptr_q] <= {coord_z, coord_y, coord_x};
		end
	end

	assign q_ctl   = ctl_q[rd_ptr_q];
	assign q_widx  = widx_q[rd_ptr_q];
	assign q_cnt   = cnt_q[rd_ptr_q];
	assign q_coord = coord_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/core/ptpd_back.sv =====
// ----------------------------------------------------------------------------
// Point-to-polyline distance back end
// Vertex store, segment walk on a shared multiplier, divider and square root.
// ----------------------------------------------------------------------------
`default_nettype none

module ptpd_back #(
	parameter int MAX_VERTICES = ptpd_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = ptpd_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  ptpd_pkg::item_ctl_t               q_ctl,
	input  logic [$clog2(MAX_VERTICES)-1:0]   q_widx,
	input  logic [$clog2(MAX_VERTICES+1)-1:0] q_cnt,
	input  logic [3*COORD_WIDTH-1:0]          q_coord,
	output logic                              empty,
	input  logic                              pop,
	output logic [ptpd_pkg::DIST_W-1:0]       distance,
	output logic                              no_segment
);
	import ptpd_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int IW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam int DW   = CW + 1;                  // coordinate differences
	localparam int NW   = 2 * CW + 3;              // dot products and squared norms
	localparam int HW   = (NW + 1) / 2;            // half word for the wide product
	localparam int MW   = ((DW > HW) ? DW : HW) + 1;
	localparam int AW   = 2 * NW + 2;
	localparam int RW   = ((2 * NW > NW + QW) ? 2 * NW : NW + QW) + 1;
	localparam int XW   = (NW > QW) ? NW : QW;

	state_t state_q, state_d;

	logic [3*CW-1:0]       mem [MAX_VERTICES];
	logic [3*CW-1:0]       rd_q;
	logic [IW-1:0]         vidx_q;
	logic [CNTW-1:0]       count_q;
	logic signed [CW-1:0]  p_q [3];
	logic signed [CW-1:0]  b_q [3];
	logic signed [CW-1:0]  rv  [3];
	logic signed [DW-1:0]  d_q [3];
	logic signed [DW-1:0]  w_q [3];
	logic signed [DW-1:0]  e_q [3];
	logic signed [NW-1:0]  dot_q;
	logic [NW-1:0]         dd_q, ww_q, ee_q;
	logic [1:0]            mk_q, ax_q;
	logic [STEP_W-1:0]     step_q;
	logic signed [AW-1:0]  acc_q;
	logic [RW-1:0]         rem_q, ds_q;
	logic [QW-1:0]         quo_q, cand_q, best_q, cand;
	logic                  wide_q;
	logic [QW-1:0]         sx_q, sres_q, sone_q, st;
	logic                  ns_q;
	logic                  res_valid_q;
	logic [DIST_W-1:0]     res_dist_q;
	logic                  res_ns_q;

	logic signed [MW-1:0]   mul_a, mul_b;
	logic signed [2*MW-1:0] prod;
	logic signed [AW-1:0]   prod_ext;
	logic [NW-1:0]          wx, wy;
	logic [1:0]             part;
	logic                   dot_le0, dot_gedd, rem_ge, seg_last, first_q;

	always_comb begin
		for (int k = 0; k < 3; k++)
			rv[k] = $signed(rd_q[k*CW +: CW]);
	end

	assign dot_le0  = dot_q[NW-1] || (dot_q == '0);
	assign dot_gedd = !dot_q[NW-1] && (unsigned'(dot_q) >= dd_q);
	assign rem_ge   = (rem_q >= ds_q);
	assign seg_last = (vidx_q == IW'(count_q - CNTW'(1)));
	assign st       = sres_q + sone_q;

	// shared multiplier: short products during MUL, half-word parts during WIDE
	always_comb begin
		wx    = step_q[2] ? unsigned'(dot_q) : ww_q;
		wy    = step_q[2] ? unsigned'(dot_q) : dd_q;
		part  = step_q[1:0];
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_WIDE) begin
			mul_a = part[1] ? $signed({{(MW-NW+HW){1'b0}}, wx[NW-1:HW]})
			                : $signed({{(MW-HW){1'b0}}, wx[HW-1:0]});
			mul_b = part[0] ? $signed({{(MW-NW+HW){1'b0}}, wy[NW-1:HW]})
			                : $signed({{(MW-HW){1'b0}}, wy[HW-1:0]});
		end else begin
			unique case (mk_q)
				2'd0: begin
					mul_a = MW'(d_q[ax_q]);
					mul_b = MW'(w_q[ax_q]);
				end
				2'd1: begin
					mul_a = MW'(d_q[ax_q]);
					mul_b = MW'(d_q[ax_q]);
				end
				2'd2: begin
					mul_a = MW'(w_q[ax_q]);
					mul_b = MW'(w_q[ax_q]);
				end
				default: begin
					mul_a = MW'(e_q[ax_q]);
					mul_b = MW'(e_q[ax_q]);
				end
			endcase
		end
		prod     = mul_a * mul_b;
		prod_ext = AW'(prod);
		unique case (part)
			2'd0:    prod_ext = prod_ext;
			2'd1,
			2'd2:    prod_ext = prod_ext <<< HW;
			default: prod_ext = prod_ext <<< (2 * HW);
		endcase
	end

	always_comb begin
		cand = wide_q ? ((quo_q > CAP) ? CAP : quo_q) : cand_q;
	end

	// next state and strobes
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_ctl.is_query)
						state_d = (count_q < CNTW'(2)) ? ST_DONE : ST_RD;
				end
			end
			ST_RD:    state_d = ST_LAT;
			ST_LAT:   state_d = first_q ? ST_RD : ST_MUL;
			ST_MUL: begin
				if (mk_q == 2'd3 && ax_q == 2'd2)
					state_d = ST_DEC;
			end
			ST_DEC:   state_d = (dot_le0 || dot_gedd) ? ST_NEXT : ST_WIDE;
			ST_WIDE: begin
				if (step_q == STEP_W'(7))
					state_d = ST_DINIT;
			end
			ST_DINIT: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_W'(QW - 1))
					state_d = ST_NEXT;
			end
			ST_NEXT:  state_d = seg_last ? ST_SQRT : ST_RD;
			ST_SQRT: begin
				if (sone_q == '0)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && q_valid && !q_ctl.is_query && q_ctl.wr_en && q_ctl.last)
				count_q <= q_cnt;
			if (state_q == ST_DONE && !res_valid_q)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
		end
	end

	// vertex store: one write port for loads, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && !q_ctl.is_query && q_ctl.wr_en)
			mem[q_widx] <= q_coord;
		rd_q <= mem[vidx_q];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				vidx_q  <= '0;
				first_q <= 1'b1;
				best_q  <= CAP;
				ns_q    <= (count_q < CNTW'(2));
				for (int k = 0; k < 3; k++)
					p_q[k] <= $signed(q_coord[k*CW +: CW]);
			end
			ST_LAT: begin
				first_q <= 1'b0;
				if (first_q)
					vidx_q <= vidx_q + IW'(1);
				for (int k = 0; k < 3; k++) begin
					b_q[k] <= rv[k];
					d_q[k] <= $signed({rv[k][CW-1], rv[k]}) - $signed({b_q[k][CW-1], b_q[k]});
					w_q[k] <= $signed({p_q[k][CW-1], p_q[k]}) - $signed({b_q[k][CW-1], b_q[k]});
					e_q[k] <= $signed({p_q[k][CW-1], p_q[k]}) - $signed({rv[k][CW-1], rv[k]});
				end
				dot_q <= '0;
				dd_q  <= '0;
				ww_q  <= '0;
				ee_q  <= '0;
				mk_q  <= 2'd0;
				ax_q  <= 2'd0;
			end
			ST_MUL: begin
				unique case (mk_q)
					2'd0:    dot_q <= dot_q + $signed(prod[NW-1:0]);
					2'd1:    dd_q  <= dd_q + prod[NW-1:0];
					2'd2:    ww_q  <= ww_q + prod[NW-1:0];
					default: ee_q  <= ee_q + prod[NW-1:0];
				endcase
				if (ax_q == 2'd2) begin
					ax_q <= 2'd0;
					mk_q <= mk_q + 2'd1;
				end else begin
					ax_q <= ax_q + 2'd1;
				end
			end
			ST_DEC: begin
				// clamp to the start or end vertex, else take the exact projection
				wide_q <= !(dot_le0 || dot_gedd);
				if (dot_le0)
					cand_q <= (XW'(ww_q) >= XW'(CAP)) ? CAP : QW'(ww_q);
				else
					cand_q <= (XW'(ee_q) >= XW'(CAP)) ? CAP : QW'(ee_q);
				acc_q  <= '0;
				step_q <= '0;
			end
			ST_WIDE: begin
				acc_q  <= step_q[2] ? acc_q - prod_ext : acc_q + prod_ext;
				step_q <= step_q + STEP_W'(1);
			end
			ST_DINIT: begin
				rem_q  <= {{(RW-2*NW){1'b0}}, acc_q[2*NW-1:0]};
				ds_q   <= RW'(dd_q) << (QW - 1);
				quo_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				if (rem_ge)
					rem_q <= rem_q - ds_q;
				quo_q  <= {quo_q[QW-2:0], rem_ge};
				ds_q   <= ds_q >> 1;
				step_q <= step_q + STEP_W'(1);
			end
			ST_NEXT: begin
				vidx_q <= vidx_q + IW'(1);
				if (cand < best_q)
					best_q <= cand;
				sx_q   <= (cand < best_q) ? cand : best_q;
				sres_q <= '0;
				sone_q <= CAP;
			end
			ST_SQRT: begin
				if (sone_q != '0) begin
					if (sx_q >= st) begin
						sx_q   <= sx_q - st;
						sres_q <= (sres_q >> 1) + sone_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sone_q <= sone_q >> 2;
				end
			end
			ST_DONE: begin
				if (!res_valid_q) begin
					res_ns_q <= ns_q;
					if (ns_q || sres_q > QW'(DIST_MAX))
						res_dist_q <= DIST_MAX;
					else
						res_dist_q <= sres_q[DIST_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign empty      = !res_valid_q;
	assign distance   = res_dist_q;
	assign no_segment = res_ns_q;

`include "point_to_polyline_distance_assert.svh"

	`PTPD_ASSERT(a_pop_has_item, !q_pop || q_valid, "queue popped while empty")
	`PTPD_ASSERT(a_div_range, (state_q != ST_DIV) || (step_q <= STEP_W'(QW - 1)), "divider overran")
	`PTPD_ASSERT_NEXT(a_res_hold, res_valid_q && !pop, res_valid_q, "waiting result dropped")
	`PTPD_ASSERT_NEXT(a_count_idle, state_q != ST_IDLE, $stable(count_q), "count changed mid-query")

endmodule

`default_nettype wire

// ===== rtl/core/point_to_polyline_distance.sv =====
// ----------------------------------------------------------------------------
// Point-to-polyline distance, top level
// Nearest distance from a 3D query point to a stored polyline.
// ----------------------------------------------------------------------------
// Both sides look like a queue. A beat with req_type = load writes one vertex
// (Q15.8) at vertex_index; a load with final_vertex set makes the polyline
// vertex_index+1 long; loads at index MAX_VERTICES or above are dropped and give
// no result. A query beat gives one result: the distance (Q16.8, truncated,
// saturating at all ones) to the nearest segment, or all ones with no_segment
// set when fewer than two vertices are stored. Items are handled one at a time
// in order; a two-deep input queue and the result register let each side stall
// on its own. A query reads each stored vertex once and, for every segment,
// forms 12 short products on the single shared multiplier; when the point
// projects inside the segment it also takes 8 half-word products there and
// the 49-step bit-serial divider. The square root takes 25 steps. The store
// has no reset; a query must only cover vertices that were loaded.
`default_nettype none

module point_to_polyline_distance #(
	parameter int MAX_VERTICES = ptpd_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = ptpd_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          req_type,
	input  logic [5:0]                    vertex_index,
	input  logic                          final_vertex,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] coord_z,
	output logic                          empty,
	input  logic                          pop,
	output logic [ptpd_pkg::DIST_W-1:0]   distance,
	output logic                          no_segment
);
	import ptpd_pkg::*;

	localparam int IW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);

	// hand-off between the front queue and the back sequencer
	logic                     q_valid;
	logic                     q_pop;
	item_ctl_t                q_ctl;
	logic [IW-1:0]            q_widx;
	logic [CNTW-1:0]          q_cnt;
	logic [3*COORD_WIDTH-1:0] q_coord;

	// accept and classify beats, hold up to two
	ptpd_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.vertex_index (vertex_index),
		.final_vertex (final_vertex),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_ctl        (q_ctl),
		.q_widx       (q_widx),
		.q_cnt        (q_cnt),
		.q_coord      (q_coord)
	);

	// store vertices, walk segments, hold the result
	ptpd_back #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_ctl        (q_ctl),
		.q_widx       (q_widx),
		.q_cnt        (q_cnt),
		.q_coord      (q_coord),
		.empty        (empty),
		.pop          (pop),
		.distance     (distance),
		.no_segment   (no_segment)
	);

endmodule

`default_nettype wire

// ===== test/tb_point_to_polyline_distance.sv =====
// ----------------------------------------------------------------------------
// Point-to-polyline distance testbench
// Loads polylines, sends query points and checks each distance beat against
// an exact-integer predictor of the nearest-segment search, with random gaps
// on both queue sides and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_point_to_polyline_distance;

	import ptpd_pkg::*;

	localparam int  NV         = 64;
	localparam int  CW         = 24;
	localparam int  CYCLE_CAP  = 40000000;
	localparam longint CMAX    = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint CMIN    = -(64'sd1 <<< (CW - 1));

	typedef struct {
		logic [DIST_W-1:0] exp_dist;
		logic              noseg;
	} answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              req_type = 1'b0;
	logic [5:0]        vertex_index = '0;
	logic              final_vertex = 1'b0;
	logic signed [CW-1:0] coord_x = '0;
	logic signed [CW-1:0] coord_y = '0;
	logic signed [CW-1:0] coord_z = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [DIST_W-1:0] distance;
	logic              no_segment;

	// Shadow copy of the polyline as the block should hold it.
	longint    poly [NV][3];
	bit        loaded [NV];
	int        poly_len = 0;

	answer_t   pending_answers[$];
	int        errors = 0;
	int        cycles = 0;
	bit        hold_request = 0;
	int        hold_left = 0;

	point_to_polyline_distance u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .vertex_index(vertex_index),
		.final_vertex(final_vertex), .coord_x(coord_x), .coord_y(coord_y),
		.coord_z(coord_z), .empty(empty), .pop(pop),
		.distance(distance), .no_segment(no_segment)
	);

	always #6 clk = ~clk;

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("MISMATCH @%0d: %s", cycles, what);
		errors++;
	endtask

	// ---------------------------------------------------------------- predictor

	function automatic logic [63:0] mag(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [127:0] sq_sum(input longint a, input longint b, input longint c);
		return 128'(mag(a)) * 128'(mag(a)) + 128'(mag(b)) * 128'(mag(b))
			+ 128'(mag(c)) * 128'(mag(c));
	endfunction

	// Clamp a squared distance to the 2^48 ceiling.
	function automatic logic [48:0] clamp48(input logic [127:0] v);
		return (v >= (128'd1 << 48)) ? (49'd1 << 48) : v[48:0];
	endfunction

	// Exact squared distance from p to the segment between vertices i and i+1.
	function automatic logic [48:0] segment_sq(input longint p [3], input int i);
		longint d [3];
		longint w [3];
		longint e [3];
		logic [127:0] pos, neg, dot, dd, num;
		pos = '0;
		neg = '0;
		for (int k = 0; k < 3; k++) begin
			d[k] = poly[i+1][k] - poly[i][k];
			w[k] = p[k] - poly[i][k];
			e[k] = p[k] - poly[i+1][k];
			if ((d[k] < 0) != (w[k] < 0))
				neg += 128'(mag(d[k])) * 128'(mag(w[k]));
			else
				pos += 128'(mag(d[k])) * 128'(mag(w[k]));
		end
		// Projection falls before the start vertex (or segment is degenerate).
		if (pos <= neg)
			return clamp48(sq_sum(w[0], w[1], w[2]));
		dot = pos - neg;
		dd = sq_sum(d[0], d[1], d[2]);
		// Projection falls past the end vertex.
		if (dot >= dd)
			return clamp48(sq_sum(e[0], e[1], e[2]));
		num = sq_sum(w[0], w[1], w[2]) * dd - dot * dot;
		if (num >= (dd << 48))
			return 49'd1 << 48;
		return 49'(num / dd);
	endfunction

	function automatic logic [DIST_W-1:0] floor_root(input logic [48:0] x);
		logic [63:0] r, t;
		r = '0;
		for (int b = 24; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= 64'(x))
				r = t;
		end
		return (r > 64'(DIST_MAX)) ? DIST_MAX : r[DIST_W-1:0];
	endfunction

	function automatic answer_t nearest_distance(input longint px, input longint py,
			input longint pz);
		answer_t   a;
		longint    p [3];
		logic [48:0] best, d2;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		if (poly_len < 2) begin
			a.exp_dist = DIST_MAX;
			a.noseg = 1'b1;
			return a;
		end
		best = 49'd1 << 48;
		for (int i = 0; i + 1 < poly_len; i++) begin
			d2 = segment_sq(p, i);
			if (d2 < best)
				best = d2;
		end
		a.exp_dist = floor_root(best);
		a.noseg = 1'b0;
		return a;
	endfunction

	// True when a query reads only vertices that were loaded.
	function automatic bit query_safe();
		for (int i = 0; i < poly_len; i++)
			if (!loaded[i])
				return 0;
		return 1;
	endfunction

	// ---------------------------------------------------------------- input side

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Offer one beat, hold it until accepted, then update the shadow state.
	task automatic send_item(input bit is_query, input int idx, input bit last,
			input longint x, input longint y, input longint z);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= is_query ? REQ_QUERY : REQ_LOAD;
		vertex_index <= 6'(idx);
		final_vertex <= last;
		coord_x <= CW'(x);
		coord_y <= CW'(y);
		coord_z <= CW'(z);
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (is_query) begin
			pending_answers.insert(pending_answers.size(), nearest_distance(x, y, z));
		end else begin
			poly[idx][0] = x;
			poly[idx][1] = y;
			poly[idx][2] = z;
			loaded[idx] = 1;
			if (last)
				poly_len = idx + 1;
		end
	endtask

	function automatic longint pick_coord(input int mode);
		case (mode)
			0: return longint'($signed(CW'($urandom)));
			1: return longint'($urandom_range(4000)) - 2000;
			2: begin
				case ($urandom_range(3))
					0: return CMIN;
					1: return CMAX;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return longint'($urandom_range(400000)) - 200000;
		endcase
	endfunction

	// ---------------------------------------------------------------- output side

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_answers.size() == 0) begin
					report($sformatf("unexpected beat distance=%0d noseg=%0b",
						distance, no_segment));
				end else begin
					answer_t a;
					a = pending_answers.pop_front();
					if (distance !== a.exp_dist)
						report($sformatf("distance got %0d want %0d",
							distance, a.exp_dist));
					if (no_segment !== a.noseg)
						report($sformatf("no_segment got %0b want %0b",
							no_segment, a.noseg));
				end
			end
			// Start a long hold-off when asked, else pop with random gaps.
			if (hold_request) begin
				hold_request = 0;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if ($urandom_range(99) < 8) begin
				hold_left = ($urandom_range(9) == 0) ? $urandom_range(60, 15)
					: $urandom_range(3, 1);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// Query with an empty and a one-vertex polyline.
	task automatic test_no_segment();
		send_item(1, 0, 0, 0, 0, 0);
		send_item(1, 17, 1, CMAX, CMIN, 5);
		send_item(0, 0, 1, 100, 200, 300);
		send_item(1, 0, 0, 100, 200, 300);
	endtask

	// Extreme coordinates, saturation, degenerate segment, on-segment point.
	task automatic test_corners();
		send_item(0, 0, 0, CMIN, CMIN, CMIN);
		send_item(0, 1, 0, CMIN, CMIN, CMIN);
		send_item(0, 2, 1, CMAX, CMAX, CMAX);
		send_item(1, 0, 0, CMIN, CMIN, CMIN);
		send_item(1, 0, 0, 0, 0, 0);
		send_item(1, 0, 0, CMAX, CMIN, CMAX);
		send_item(1, 0, 0, CMIN, CMAX, CMAX);
		// Degenerate pair, then a short segment with inside and end projections.
		send_item(0, 0, 0, 512, -256, 0);
		send_item(0, 1, 0, 512, -256, 0);
		send_item(0, 2, 0, 1024, 0, 256);
		send_item(0, 3, 1, -3000, 777, 1);
		send_item(1, 0, 0, 700, -100, 90);
		send_item(1, 0, 0, 512, -256, 0);
		send_item(1, 0, 0, -9000, 5000, -40);
		send_item(1, 0, 0, CMAX, CMAX, CMIN);
	endtask

	// Full-length polyline, final vertex at the top index.
	task automatic test_full_polyline();
		for (int i = 0; i < NV; i++)
			send_item(0, i, i == NV - 1, pick_coord(3), pick_coord(3), pick_coord(3));
		repeat (3)
			send_item(1, 0, 0, pick_coord(3), pick_coord(3), pick_coord(3));
	endtask

	// Stall the output long enough for the input queue to back up.
	task automatic test_backpressure();
		send_item(0, 0, 0, -500, 0, 0);
		send_item(0, 1, 1, 500, 10, 0);
		hold_request = 1;
		repeat (12)
			send_item(1, 0, 0, pick_coord(1), pick_coord(1), pick_coord(1));
	endtask

	// Well-formed load sets with random queries, mixed with loose beats.
	task automatic test_random(input int budget);
		int sent, n, mode, order;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 80) begin
				n = ($urandom_range(99) < 2) ? $urandom_range(NV, 32)
					: $urandom_range(6, 2);
				mode = $urandom_range(3);
				order = $urandom_range(1);
				// Load in order or in reverse; the final flag sits on the top index.
				for (int j = 0; j < n; j++) begin
					int idx;
					idx = order ? j : n - 1 - j;
					send_item(0, idx, idx == n - 1, pick_coord(mode), pick_coord(mode),
						pick_coord(mode));
				end
				sent += n;
				for (int q = $urandom_range(5, 2); q > 0; q--) begin
					send_item(1, $urandom_range(63), $urandom_range(1),
						pick_coord(mode), pick_coord(mode), pick_coord(mode));
					sent++;
				end
			end else if ($urandom_range(1)) begin
				send_item(0, $urandom_range(5), $urandom_range(1), pick_coord(0),
					pick_coord(0), pick_coord(0));
				sent++;
			end else if (query_safe() && poly_len <= 8) begin
				send_item(1, $urandom_range(63), $urandom_range(1), pick_coord(0),
					pick_coord(0), pick_coord(0));
				sent++;
			end
		end
		// Leave loose loads behind only at lengths the store fully covers.
		if (!query_safe()) begin
			send_item(0, 0, 1, 0, 0, 0);
			send_item(1, 0, 0, 1, 2, 3);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_segment();
		test_corners();
		test_backpressure();
		test_full_polyline();
		test_random(1750);
		push <= 1'b0;
		// Drain, then give the block time to show any stray beat.
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (pending_answers.size() != 0)
			report("expected beats left over");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== point_to_polyline_distance.f =====
+incdir+rtl/core
rtl/core/ptpd_pkg.sv
rtl/core/ptpd_front.sv
rtl/core/ptpd_back.sv
rtl/core/point_to_polyline_distance.sv
test/tb_point_to_polyline_distance.sv
